// ===== src/lpsc_pkg.sv =====
`default_nettype none

package lpsc_pkg;

    localparam int DEFAULT_SENSOR_COUNT = 15;
    localparam int QUEUE_DEPTH          = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEERING_CENTER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEAD_CENTER     = 2'd1;

    localparam int STEER_W = 11;
    localparam int HEAD_W  = 10;
    localparam int POS_W   = 5;
    localparam int ERR_W   = 11;
    localparam int INC_W   = 11;

    localparam logic [STEER_W-1:0] STEER_MIN          = 11'd1198;
    localparam logic [STEER_W-1:0] STEER_MAX          = 11'd1778;
    localparam logic [STEER_W-1:0] STEER_CENTER_RESET = 11'd1488;
    localparam logic [HEAD_W-1:0]  HEAD_MAX           = 10'd1000;
    localparam logic [HEAD_W-1:0]  HEAD_CENTER_RESET  = 10'd224;

    // Reciprocals scaled by 2**RECIP_SHIFT, exact for magnitudes below 2**14.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_5  = 18'd209716;
    localparam logic [RECIP_W-1:0] RECIP_6  = 18'd174763;
    localparam logic [RECIP_W-1:0] RECIP_11 = 18'd95326;

    typedef enum logic [1:0] {
        DIV_BY_5,
        DIV_BY_6,
        DIV_BY_11
    } divisor_t;

    typedef enum logic [2:0] {
        HB_ZERO,
        HB_LOW,
        HB_MID,
        HB_HIGH,
        HB_TOP,
        HB_HOLD
    } head_band_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_POS,
        BACK_MUL_D,
        BACK_MUL_P,
        BACK_MUL_G,
        BACK_FINAL
    } back_state_t;

    function automatic int sum_width(input int n);
        return $clog2(n * (2 * n + 14) + 1) + 1;
    endfunction

    function automatic int count_width(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

`default_nettype wire

// ===== src/lpsc_front.sv =====
`default_nettype none

module lpsc_front #(
    parameter int SENSOR_COUNT = lpsc_pkg::DEFAULT_SENSOR_COUNT,
    localparam int SUM_W  = lpsc_pkg::sum_width(SENSOR_COUNT),
    localparam int CNT_W  = lpsc_pkg::count_width(SENSOR_COUNT),
    localparam int WORD_W = SUM_W + CNT_W + 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SENSOR_COUNT-1:0] s_sensor_mask,
    input  wire logic                    s_head_step,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output logic [WORD_W-1:0]            push_word
);

    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        cnt_next;
    logic [WORD_W-1:0]       word_reg;
    logic                    valid_reg;

    always_comb begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (s_sensor_mask[i]) begin
                sum_next = sum_next + SUM_W'(14 - 2 * i);
                cnt_next = cnt_next + CNT_W'(1);
            end
        end
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= {sum_next, cnt_next, s_head_step};
        end
    end

endmodule

`default_nettype wire

// ===== src/lpsc_queue.sv =====
`default_nettype none

module lpsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_word
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != FILL_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/lpsc_back.sv =====
`default_nettype none

module lpsc_back #(
    parameter int SENSOR_COUNT = lpsc_pkg::DEFAULT_SENSOR_COUNT,
    localparam int SUM_W  = lpsc_pkg::sum_width(SENSOR_COUNT),
    localparam int CNT_W  = lpsc_pkg::count_width(SENSOR_COUNT),
    localparam int WORD_W = SUM_W + CNT_W + 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             pop_valid,
    output logic                                  pop_ready,
    input  wire logic [WORD_W-1:0]                pop_word,
    input  wire logic                             cfg_valid,
    input  wire logic [lpsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lpsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lpsc_pkg::STEER_W-1:0]          m_steering_duty,
    output logic [lpsc_pkg::HEAD_W-1:0]           m_head_duty,
    output logic signed [lpsc_pkg::POS_W-1:0]     m_line_position,
    output logic                                  m_no_line
);

    localparam int ITER_W = $clog2(SUM_W);
    localparam int OP_W   = 15;
    localparam int MAG_W  = OP_W - 1;
    localparam int PROD_W = MAG_W + lpsc_pkg::RECIP_W;
    localparam int Q_W    = PROD_W - lpsc_pkg::RECIP_SHIFT;

    lpsc_pkg::back_state_t state_reg, state_next;

    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      head_step_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [lpsc_pkg::POS_W-1:0] pos_reg;
    logic                      none_reg;
    logic signed [lpsc_pkg::ERR_W-1:0] e_reg;
    logic                      hold_center_reg;
    logic [3:0]                kp_reg;
    logic [2:0]                ke_reg;
    logic signed [10:0]        q5d_reg;
    logic signed [15:0]        kpe_reg;
    logic signed [4:0]         term1_reg;
    logic signed [10:0]        term2_reg;

    logic [lpsc_pkg::STEER_W-1:0]      steer_center_reg;
    logic [lpsc_pkg::HEAD_W-1:0]       head_center_reg;
    logic signed [lpsc_pkg::POS_W-1:0] last_pos_reg;
    logic [lpsc_pkg::HEAD_W-1:0]       head_duty_reg;
    logic signed [lpsc_pkg::ERR_W-1:0] prev_err_reg;
    logic signed [lpsc_pkg::INC_W-1:0] head_inc_reg;
    logic signed [lpsc_pkg::INC_W-1:0] prev_inc_reg;

    logic                              m_valid_reg;
    logic [lpsc_pkg::STEER_W-1:0]      out_steer_reg;
    logic [lpsc_pkg::HEAD_W-1:0]       out_head_reg;
    logic signed [lpsc_pkg::POS_W-1:0] out_pos_reg;
    logic                              out_none_reg;

    logic signed [SUM_W-1:0] pop_sum;
    logic [CNT_W-1:0]        pop_cnt;
    logic                    pop_head;
    logic                    out_free;

    logic [CNT_W:0]          rem_shift;
    logic                    rem_ge;
    logic [CNT_W:0]          rem_new;

    logic signed [lpsc_pkg::POS_W-1:0] pos_new;
    logic signed [11:0]                e_wide;
    logic [10:0]                       ae;

    logic [4:0]               ap;
    lpsc_pkg::head_band_t     hband;

    logic signed [OP_W-1:0]   recip_op;
    lpsc_pkg::divisor_t       recip_sel;
    logic [MAG_W-1:0]         recip_mag;
    logic [lpsc_pkg::RECIP_W-1:0] recip_const;
    logic [PROD_W-1:0]        recip_prod;
    logic signed [Q_W:0]      recip_q;

    logic signed [OP_W-1:0]   pos15;
    logic signed [OP_W-1:0]   d15;
    logic signed [OP_W-1:0]   g15;
    logic signed [11:0]       d_wide;
    logic signed [11:0]       g_wide;

    logic signed [15:0]       kp_ext;
    logic signed [15:0]       ke_ext;
    logic signed [15:0]       posk_ext;
    logic signed [15:0]       ek_ext;

    logic signed [16:0]       duty_raw;
    logic [lpsc_pkg::STEER_W-1:0] duty_next;
    logic signed [11:0]       inc_sum;
    logic signed [lpsc_pkg::INC_W-1:0] inc_next;
    logic signed [11:0]       head_sum;
    logic [lpsc_pkg::HEAD_W-1:0] head_duty_next;

    assign pop_sum  = pop_word[WORD_W-1 -: SUM_W];
    assign pop_cnt  = pop_word[CNT_W:1];
    assign pop_head = pop_word[0];

    assign pop_ready = (state_reg == lpsc_pkg::BACK_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_steering_duty = out_steer_reg;
    assign m_head_duty     = out_head_reg;
    assign m_line_position = out_pos_reg;
    assign m_no_line       = out_none_reg;

    // One restoring division step per cycle, quotient bits shifted in at the bottom.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, cnt_reg});
        rem_new   = rem_ge ? rem_shift - {1'b0, cnt_reg} : rem_shift;
    end

    always_comb begin
        if (cnt_reg == '0) begin
            pos_new = last_pos_reg;
        end else if (!sum_reg[SUM_W-1]) begin
            pos_new = (quo_reg > SUM_W'(15)) ? 5'sd15 : lpsc_pkg::POS_W'(quo_reg);
        end else begin
            pos_new = (quo_reg > SUM_W'(16)) ? -5'sd16 : lpsc_pkg::POS_W'(-quo_reg);
        end
        e_wide = $signed({2'b00, head_duty_reg}) - $signed({2'b00, head_center_reg});
        ae     = e_wide[11] ? 11'(-e_wide) : e_wide[10:0];
    end

    always_comb begin
        ap = pos_reg[4] ? 5'(-pos_reg) : pos_reg;
        priority if (ap <= 5'd1) begin
            hband = lpsc_pkg::HB_ZERO;
        end else if (ap <= 5'd3) begin
            hband = lpsc_pkg::HB_LOW;
        end else if (ap <= 5'd7) begin
            hband = lpsc_pkg::HB_MID;
        end else if (ap <= 5'd10) begin
            hband = lpsc_pkg::HB_HIGH;
        end else if (ap <= 5'd14) begin
            hband = lpsc_pkg::HB_TOP;
        end else begin
            hband = lpsc_pkg::HB_HOLD;
        end
    end

    always_comb begin
        pos15  = {{(OP_W - lpsc_pkg::POS_W){pos_reg[4]}}, pos_reg};
        d_wide = {e_reg[10], e_reg} - {prev_err_reg[10], prev_err_reg};
        d15    = {{(OP_W - 12){d_wide[11]}}, d_wide};
        g_wide = {head_inc_reg[10], head_inc_reg} - {prev_inc_reg[10], prev_inc_reg};
        g15    = {{(OP_W - 12){g_wide[11]}}, g_wide};
        recip_op  = '0;
        recip_sel = lpsc_pkg::DIV_BY_11;
        unique case (state_reg)
            lpsc_pkg::BACK_MUL_D: begin
                recip_op  = (d15 <<< 2) + d15;
                recip_sel = lpsc_pkg::DIV_BY_11;
            end
            lpsc_pkg::BACK_MUL_P: begin
                if (hband == lpsc_pkg::HB_HIGH) begin
                    recip_op = (pos15 <<< 2) + pos15;
                end else begin
                    recip_op = pos15 <<< 2;
                end
                recip_sel = (hband == lpsc_pkg::HB_LOW) ? lpsc_pkg::DIV_BY_5
                                                         : lpsc_pkg::DIV_BY_6;
            end
            lpsc_pkg::BACK_MUL_G: begin
                if (hband == lpsc_pkg::HB_LOW || hband == lpsc_pkg::HB_MID) begin
                    recip_op = (g15 <<< 1) + g15;
                end else begin
                    recip_op = g15 <<< 2;
                end
                recip_sel = lpsc_pkg::DIV_BY_11;
            end
            default: begin
                recip_op  = '0;
                recip_sel = lpsc_pkg::DIV_BY_11;
            end
        endcase
    end

    // Division by a constant as a multiplication by its scaled reciprocal, truncated toward zero.
    always_comb begin
        unique case (recip_sel)
            lpsc_pkg::DIV_BY_5:  recip_const = lpsc_pkg::RECIP_5;
            lpsc_pkg::DIV_BY_6:  recip_const = lpsc_pkg::RECIP_6;
            lpsc_pkg::DIV_BY_11: recip_const = lpsc_pkg::RECIP_11;
            default:             recip_const = lpsc_pkg::RECIP_11;
        endcase
        recip_mag  = recip_op[OP_W-1] ? MAG_W'(-recip_op) : recip_op[MAG_W-1:0];
        recip_prod = PROD_W'(recip_mag) * PROD_W'(recip_const);
        recip_q    = recip_op[OP_W-1] ? -$signed({1'b0, recip_prod[PROD_W-1 -: Q_W]})
                                      : $signed({1'b0, recip_prod[PROD_W-1 -: Q_W]});
    end

    always_comb begin
        kp_ext   = {12'd0, kp_reg};
        ke_ext   = {13'd0, ke_reg};
        posk_ext = {{(16 - lpsc_pkg::POS_W){pos_reg[4]}}, pos_reg};
        ek_ext   = {{(16 - lpsc_pkg::ERR_W){e_reg[10]}}, e_reg};

        if (hold_center_reg) begin
            duty_raw = $signed({6'd0, steer_center_reg});
        end else begin
            duty_raw = $signed({6'd0, steer_center_reg}) - {kpe_reg[15], kpe_reg}
                       - {{6{q5d_reg[10]}}, q5d_reg};
        end
        if (duty_raw < $signed({6'd0, lpsc_pkg::STEER_MIN})) begin
            duty_next = lpsc_pkg::STEER_MIN;
        end else if (duty_raw > $signed({6'd0, lpsc_pkg::STEER_MAX})) begin
            duty_next = lpsc_pkg::STEER_MAX;
        end else begin
            duty_next = duty_raw[lpsc_pkg::STEER_W-1:0];
        end

        inc_sum = {{7{term1_reg[4]}}, term1_reg} + {term2_reg[10], term2_reg};
        if (hband == lpsc_pkg::HB_HOLD) begin
            inc_next = head_inc_reg;
        end else if (hband == lpsc_pkg::HB_ZERO) begin
            inc_next = '0;
        end else if (inc_sum < -12'sd1024) begin
            inc_next = -11'sd1024;
        end else if (inc_sum > 12'sd1023) begin
            inc_next = 11'sd1023;
        end else begin
            inc_next = inc_sum[lpsc_pkg::INC_W-1:0];
        end

        head_sum = $signed({2'b00, head_duty_reg}) + {inc_next[10], inc_next};
        if (head_sum < 12'sd0) begin
            head_duty_next = '0;
        end else if (head_sum > $signed({2'b00, lpsc_pkg::HEAD_MAX})) begin
            head_duty_next = lpsc_pkg::HEAD_MAX;
        end else begin
            head_duty_next = head_sum[lpsc_pkg::HEAD_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpsc_pkg::BACK_IDLE: begin
                if (pop_valid) begin
                    state_next = (pop_cnt == '0) ? lpsc_pkg::BACK_POS : lpsc_pkg::BACK_DIV;
                end
            end
            lpsc_pkg::BACK_DIV: begin
                if (iter_reg == '0) begin
                    state_next = lpsc_pkg::BACK_POS;
                end
            end
            lpsc_pkg::BACK_POS:   state_next = lpsc_pkg::BACK_MUL_D;
            lpsc_pkg::BACK_MUL_D: state_next = lpsc_pkg::BACK_MUL_P;
            lpsc_pkg::BACK_MUL_P: state_next = lpsc_pkg::BACK_MUL_G;
            lpsc_pkg::BACK_MUL_G: state_next = lpsc_pkg::BACK_FINAL;
            lpsc_pkg::BACK_FINAL: begin
                if (out_free) begin
                    state_next = lpsc_pkg::BACK_IDLE;
                end
            end
            default: state_next = lpsc_pkg::BACK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpsc_pkg::BACK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lpsc_pkg::BACK_IDLE: begin
                sum_reg       <= pop_sum;
                cnt_reg       <= pop_cnt;
                head_step_reg <= pop_head;
                quo_reg       <= pop_sum[SUM_W-1] ? SUM_W'(-pop_sum) : pop_sum;
                rem_reg       <= '0;
                iter_reg      <= ITER_W'(SUM_W - 1);
            end
            lpsc_pkg::BACK_DIV: begin
                rem_reg  <= rem_new[CNT_W-1:0];
                quo_reg  <= {quo_reg[SUM_W-2:0], rem_ge};
                iter_reg <= iter_reg - ITER_W'(1);
            end
            lpsc_pkg::BACK_POS: begin
                pos_reg         <= pos_new;
                none_reg        <= (cnt_reg == '0);
                e_reg           <= e_wide[lpsc_pkg::ERR_W-1:0];
                hold_center_reg <= (ae <= 11'd8);
                priority if (ae <= 11'd14) begin
                    kp_reg <= 4'd4;
                    ke_reg <= 3'd1;
                end else if (ae <= 11'd24) begin
                    kp_reg <= 4'd6;
                    ke_reg <= 3'd3;
                end else if (ae <= 11'd40) begin
                    kp_reg <= 4'd8;
                    ke_reg <= 3'd4;
                end else if (ae <= 11'd60) begin
                    kp_reg <= 4'd9;
                    ke_reg <= 3'd5;
                end else if (ae <= 11'd80) begin
                    kp_reg <= 4'd11;
                    ke_reg <= 3'd6;
                end else begin
                    kp_reg <= 4'd11;
                    ke_reg <= 3'd7;
                end
            end
            lpsc_pkg::BACK_MUL_D: begin
                q5d_reg <= 11'(recip_q);
                kpe_reg <= kp_ext * posk_ext + ke_ext * ek_ext;
            end
            lpsc_pkg::BACK_MUL_P: begin
                term1_reg <= 5'(recip_q);
            end
            lpsc_pkg::BACK_MUL_G: begin
                term2_reg <= 11'(recip_q);
            end
            lpsc_pkg::BACK_FINAL: begin
                if (out_free) begin
                    out_steer_reg <= duty_next;
                    out_head_reg  <= head_step_reg ? head_duty_next : head_duty_reg;
                    out_pos_reg   <= pos_reg;
                    out_none_reg  <= none_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            steer_center_reg <= lpsc_pkg::STEER_CENTER_RESET;
            head_center_reg  <= lpsc_pkg::HEAD_CENTER_RESET;
            last_pos_reg     <= '0;
            head_duty_reg    <= lpsc_pkg::HEAD_CENTER_RESET;
            prev_err_reg     <= '0;
            head_inc_reg     <= '0;
            prev_inc_reg     <= '0;
        end else begin
            if (state_reg == lpsc_pkg::BACK_FINAL && out_free) begin
                m_valid_reg  <= 1'b1;
                last_pos_reg <= pos_reg;
                prev_err_reg <= e_reg;
                if (head_step_reg) begin
                    prev_inc_reg  <= head_inc_reg;
                    head_inc_reg  <= inc_next;
                    head_duty_reg <= head_duty_next;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_addr == lpsc_pkg::CFG_STEERING_CENTER) begin
                    steer_center_reg <= cfg_data[lpsc_pkg::STEER_W-1:0];
                end else if (cfg_addr == lpsc_pkg::CFG_HEAD_CENTER) begin
                    head_center_reg <= cfg_data[lpsc_pkg::HEAD_W-1:0];
                    head_duty_reg   <= (cfg_data[lpsc_pkg::HEAD_W-1:0] > lpsc_pkg::HEAD_MAX)
                                       ? lpsc_pkg::HEAD_MAX : cfg_data[lpsc_pkg::HEAD_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/line_position_steering_control.sv =====
// Line-position steering controller.
// Each word on the s_ channel carries one control tick: a sensor mask and a
// head_step flag. Each tick produces exactly one word on the m_ channel with
// the clamped steering duty, the head servo duty, the line position and the
// no-line flag. Both channels use valid and ready handshakes.
// Registers must be written through the cfg_ channel only while the block is
// idle; the block itself does not enforce this. Index 0 sets the steering centre,
// index 1 sets the head centre and reloads the head duty. Other indices are
// ignored; cfg_ready is always high. A front stage computes the weighted sum
// and hit count and passes them through a two-word queue to the back end. The
// back end takes one word at a time and uses a bit-serial divider that
// produces one quotient bit per cycle; a tick with no sensor set skips the
// divider. When the receiver stalls, the result is held in the output
// register, the back end waits in its last step and the queue and front stage
// go on accepting words until they are full. Reset clears all control state
// and restores the register and servo reset values.
`default_nettype none

module line_position_steering_control #(
    parameter int SENSOR_COUNT = lpsc_pkg::DEFAULT_SENSOR_COUNT,
    parameter int QUEUE_DEPTH  = lpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [SENSOR_COUNT-1:0]          s_sensor_mask,
    input  wire logic                             s_head_step,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lpsc_pkg::STEER_W-1:0]          m_steering_duty,
    output logic [lpsc_pkg::HEAD_W-1:0]           m_head_duty,
    output logic signed [lpsc_pkg::POS_W-1:0]     m_line_position,
    output logic                                  m_no_line,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lpsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lpsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W  = lpsc_pkg::sum_width(SENSOR_COUNT);
    localparam int CNT_W  = lpsc_pkg::count_width(SENSOR_COUNT);
    localparam int WORD_W = SUM_W + CNT_W + 1;

    logic              push_valid;
    logic              push_ready;
    logic [WORD_W-1:0] push_word;
    logic              pop_valid;
    logic              pop_ready;
    logic [WORD_W-1:0] pop_word;

    assign cfg_ready = 1'b1;

    lpsc_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sensor_mask (s_sensor_mask),
        .s_head_step   (s_head_step),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_word     (push_word)
    );

    lpsc_queue #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_word   (push_word),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_word  (pop_word)
    );

    lpsc_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_word        (pop_word),
        .cfg_valid       (cfg_valid),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_steering_duty (m_steering_duty),
        .m_head_duty     (m_head_duty),
        .m_line_position (m_line_position),
        .m_no_line       (m_no_line)
    );

endmodule

`default_nettype wire

// ===== tb/sv/line_position_steering_control_test.sv =====
`default_nettype none

module line_position_steering_control_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lpsc_pkg::*;

    localparam int SENSORS       = DEFAULT_SENSOR_COUNT;
    localparam int STEER_LO      = STEER_MIN;
    localparam int STEER_HI      = STEER_MAX;
    localparam int HEAD_HI       = HEAD_MAX;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        logic [STEER_W-1:0]      steering_duty;
        logic [HEAD_W-1:0]       head_duty;
        logic signed [POS_W-1:0] line_position;
        logic                    no_line;
    } tick_result_t;

    typedef struct {
        logic [SENSORS-1:0] mask;
        logic               head_step;
        int                 gap;
    } tick_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [SENSORS-1:0]      s_sensor_mask = '0;
    logic                    s_head_step   = 1'b0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [STEER_W-1:0]      m_steering_duty;
    logic [HEAD_W-1:0]       m_head_duty;
    logic signed [POS_W-1:0] m_line_position;
    logic                    m_no_line;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_ADDR_W-1:0]   cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    tick_item_t   pending_ticks[$];
    tick_result_t expected_results[$];

    // Predicted block state and register copies.
    int steer_center_cfg;
    int head_center_cfg;
    int held_position;
    int head_duty_state;
    int last_head_error;
    int head_incr;
    int prev_head_incr;

    int ticks_queued   = 0;
    int ticks_accepted = 0;
    int words_checked  = 0;
    int fault_count    = 0;
    int reg_writes     = 0;
    int no_line_words  = 0;
    int head_ticks     = 0;
    int clamped_steers = 0;
    int cycle_count    = 0;
    int tx_wait        = 0;
    int rx_wait        = 0;
    int hold_left      = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;

    line_position_steering_control u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_mask   (s_sensor_mask),
        .s_head_step     (s_head_step),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_steering_duty (m_steering_duty),
        .m_head_duty     (m_head_duty),
        .m_line_position (m_line_position),
        .m_no_line       (m_no_line),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic tick_result_t compute_tick(input logic [SENSORS-1:0] mask,
                                                  input logic head);
        tick_result_t r;
        int wsum;
        int hits;
        int pos;
        int err;
        int abs_err;
        int kp;
        int ke;
        int duty;
        int abs_pos;
        int grad;
        int incr;
        wsum = 0;
        hits = 0;
        for (int i = 0; i < SENSORS; i++) begin
            if (mask[i]) begin
                wsum += 14 - 2 * i;
                hits++;
            end
        end
        if (hits == 0) begin
            pos = held_position;
        end else begin
            pos = clamp_int(wsum / hits, -16, 15);
        end
        held_position = pos;

        err     = head_duty_state - head_center_cfg;
        abs_err = (err < 0) ? -err : err;
        if (abs_err <= 8) begin
            duty = steer_center_cfg;
        end else begin
            if (abs_err <= 14) begin
                kp = 4;  ke = 1;
            end else if (abs_err <= 24) begin
                kp = 6;  ke = 3;
            end else if (abs_err <= 40) begin
                kp = 8;  ke = 4;
            end else if (abs_err <= 60) begin
                kp = 9;  ke = 5;
            end else if (abs_err <= 80) begin
                kp = 11; ke = 6;
            end else begin
                kp = 11; ke = 7;
            end
            duty = steer_center_cfg - (kp * pos + ke * err) - (5 * (err - last_head_error)) / 11;
        end
        if (duty < STEER_LO || duty > STEER_HI) begin
            clamped_steers++;
        end
        duty = clamp_int(duty, STEER_LO, STEER_HI);
        last_head_error = err;

        if (head) begin
            abs_pos = (pos < 0) ? -pos : pos;
            grad    = head_incr - prev_head_incr;
            incr    = head_incr;
            if (abs_pos <= 1) begin
                incr = 0;
            end else if (abs_pos <= 3) begin
                incr = (4 * pos) / 5 + (3 * grad) / 11;
            end else if (abs_pos <= 7) begin
                incr = (4 * pos) / 6 + (3 * grad) / 11;
            end else if (abs_pos <= 10) begin
                incr = (5 * pos) / 6 + (4 * grad) / 11;
            end else if (abs_pos <= 14) begin
                incr = (4 * pos) / 6 + (4 * grad) / 11;
            end
            incr            = clamp_int(incr, -1024, 1023);
            prev_head_incr  = head_incr;
            head_incr       = incr;
            head_duty_state = clamp_int(head_duty_state + incr, 0, HEAD_HI);
        end

        r.steering_duty = duty[STEER_W-1:0];
        r.head_duty     = head_duty_state[HEAD_W-1:0];
        r.line_position = pos[POS_W-1:0];
        r.no_line       = (hits == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words still awaited.",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin : sender
        tick_item_t   it;
        tick_result_t predicted;
        logic         offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                predicted = compute_tick(s_sensor_mask, s_head_step);
                expected_results.push_back(predicted);
                ticks_accepted++;
                if (s_head_step) begin
                    head_ticks++;
                end
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_wait > 0) begin
                    tx_wait <= tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    it = pending_ticks.pop_front();
                    s_valid       <= 1'b1;
                    s_sensor_mask <= it.mask;
                    s_head_step   <= it.head_step;
                    tx_wait       <= it.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : long_hold
        if (!aresetn) begin
            hold_left    <= 0;
            holds_served <= 0;
        end else if (holds_served != hold_requests) begin
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : receiver
        tick_result_t want;
        int           wait_n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            wait_n = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (m_valid && m_ready) begin
                words_checked++;
                if (m_no_line) begin
                    no_line_words++;
                end
                if (expected_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected word: steer %0d head %0d pos %0d nl %0b",
                                 $realtime, m_steering_duty, m_head_duty, m_line_position,
                                 m_no_line);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_steering_duty !== want.steering_duty || m_head_duty !== want.head_duty
                        || m_line_position !== want.line_position
                        || m_no_line !== want.no_line) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display("%0t: word %0d: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                     $realtime, words_checked, want.steering_duty,
                                     want.head_duty, want.line_position, want.no_line,
                                     m_steering_duty, m_head_duty, m_line_position, m_no_line);
                        end
                    end
                end
                wait_n = rx_gaps_on ? $urandom_range(0, 15) : 0;
            end
            rx_wait <= wait_n;
            m_ready <= (wait_n == 0) && (hold_left == 0);
        end
    end

    task automatic queue_tick(input logic [SENSORS-1:0] mask, input logic head);
        tick_item_t it;
        it.mask      = mask;
        it.head_step = head;
        it.gap       = tx_gaps_on ? $urandom_range(0, 15) : 0;
        pending_ticks.push_back(it);
        ticks_queued++;
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_STEERING_CENTER: begin
                steer_center_cfg = data;
            end
            CFG_HEAD_CENTER: begin
                head_center_cfg = data[HEAD_W-1:0];
                head_duty_state = clamp_int(head_center_cfg, 0, HEAD_HI);
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_until_drained();
        while (ticks_accepted != ticks_queued || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SENSORS-1:0] random_mask();
        int span;
        int first;
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2, 3: return SENSORS'(1) << $urandom_range(0, SENSORS - 1);
            4, 5, 6: begin
                span  = $urandom_range(2, 4);
                first = $urandom_range(0, SENSORS - span);
                return SENSORS'(((1 << span) - 1) << first);
            end
            default: return SENSORS'($urandom_range(0, (1 << SENSORS) - 1));
        endcase
    endfunction

    // A drift burst keeps the line on one side of the sensor array with head updates.
    task automatic queue_random_ticks(input int count);
        int  made;
        int  burst;
        bit  left;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 2) begin
                burst = $urandom_range(5, 15);
                left  = ($urandom_range(0, 1) != 0);
                for (int k = 0; k < burst; k++) begin
                    if (left) begin
                        queue_tick(SENSORS'(1) << $urandom_range(0, 4), 1'b1);
                    end else begin
                        queue_tick(SENSORS'(1) << $urandom_range(SENSORS - 5, SENSORS - 1),
                                   1'b1);
                    end
                end
                made += burst;
            end else begin
                queue_tick(random_mask(), $urandom_range(0, 9) < 6);
                made++;
            end
        end
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] steer;
        logic [CFG_DATA_W-1:0] head;
        steer = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(STEER_LO, STEER_HI))
                                           : CFG_DATA_W'($urandom_range(0, 2047));
        head  = ($urandom_range(0, 9) < 2) ? CFG_DATA_W'($urandom_range(1001, 1023))
                                           : CFG_DATA_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 1)) begin
            write_register(CFG_STEERING_CENTER, steer);
            write_register(CFG_HEAD_CENTER, head);
        end else begin
            write_register(CFG_HEAD_CENTER, head);
            write_register(CFG_STEERING_CENTER, steer);
        end
        if ($urandom_range(0, 2) == 0) begin
            write_register($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                           CFG_DATA_W'($urandom_range(0, 2047)));
        end
    endtask

    initial begin : stimulus
        steer_center_cfg = STEER_CENTER_RESET;
        head_center_cfg  = HEAD_CENTER_RESET;
        head_duty_state  = HEAD_CENTER_RESET;
        held_position    = 0;
        last_head_error  = 0;
        head_incr        = 0;
        prev_head_incr   = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes of the mask, every weight region and a no-line tick first.
        queue_tick(15'h0000, 1'b0);
        queue_tick(15'h0001, 1'b1);
        queue_tick(15'h4000, 1'b1);
        queue_tick(15'h7FFF, 1'b0);
        queue_tick(15'h0000, 1'b1);
        queue_tick(15'h0003, 1'b1);
        queue_tick(15'h0007, 1'b1);
        queue_tick(15'h000F, 1'b1);
        queue_tick(15'h0010, 1'b1);
        queue_tick(15'h0020, 1'b1);
        queue_tick(15'h0040, 1'b1);
        queue_tick(15'h0080, 1'b1);
        queue_tick(15'h0180, 1'b1);
        queue_tick(15'h0100, 1'b1);
        queue_tick(15'h0200, 1'b1);
        queue_tick(15'h0800, 1'b1);
        queue_tick(15'h6000, 1'b1);
        queue_tick(15'h0000, 1'b1);
        for (int k = 0; k < 5; k++) begin
            queue_tick(15'h0001, 1'b1);
        end
        queue_tick(15'h5555, 1'b0);
        queue_tick(15'h2AAA, 1'b1);
        queue_tick(15'h7FFE, 1'b1);
        wait_until_drained();

        write_register(CFG_STEERING_CENTER, CFG_DATA_W'(STEER_LO));
        write_register(CFG_HEAD_CENTER, CFG_DATA_W'(0));
        queue_random_ticks(200);
        wait_until_drained();

        // Back-to-back offers against a long receiver hold, so the block backs up.
        write_register(CFG_STEERING_CENTER, CFG_DATA_W'(STEER_HI));
        write_register(CFG_HEAD_CENTER, CFG_DATA_W'(HEAD_HI));
        tx_gaps_on = 1'b0;
        queue_random_ticks(200);
        hold_requests <= hold_requests + 1;
        wait_until_drained();

        write_register(CFG_STEERING_CENTER, CFG_DATA_W'(0));
        write_register(CFG_HEAD_CENTER, CFG_DATA_W'(11'h3FF));
        write_register(CFG_UNMAPPED_A, CFG_DATA_W'(11'h7FF));
        write_register(CFG_UNMAPPED_B, CFG_DATA_W'(11'h555));
        rx_gaps_on = 1'b0;
        queue_random_ticks(200);
        wait_until_drained();

        write_register(CFG_STEERING_CENTER, CFG_DATA_W'(11'h7FF));
        write_register(CFG_HEAD_CENTER, CFG_DATA_W'(11'h400 | 11'd500));
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        queue_random_ticks(200);
        wait_until_drained();

        for (int phase = 0; phase < 6; phase++) begin
            random_settings();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            queue_random_ticks(200);
            if (phase == 3) begin
                hold_requests <= hold_requests + 1;
            end
            wait_until_drained();
        end

        fault_count += expected_results.size();
        $display("Checked %0d result words from %0d ticks (%0d head updates, %0d with no line).",
                 words_checked, ticks_accepted, head_ticks, no_line_words);
        $display("Register writes: %0d; steering duty clamped on %0d ticks.",
                 reg_writes, clamped_steers);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
